// File: design/ptb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and controller codes for the per-flow token bucket.
package ptb_pkg;

  localparam int PTB_FLOWS     = 1024;
  localparam int PTB_FRAC_BITS = 16;

  localparam int FLOW_W    = 10;
  localparam int CELL_W    = 32;
  localparam int TICK_W    = 48;
  localparam int RATE_W    = 32;
  localparam int WAIT_W    = 56;
  localparam int MUL_W     = 32;
  localparam int CFG_W     = 32;
  localparam int REG_IDX_W = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_REFILL_RATE = 1'b0,
    REG_BURST_SIZE  = 1'b1
  } ptb_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_REFILL,
    S_CHARGE,
    S_DIV,
    S_RESULT
  } ptb_state_t;

  typedef struct packed {
    logic clear;
    logic load_in;
    logic read;
    logic load_entry;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic refill;
    logic charge;
    logic out_load;
  } ptb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rate_zero;
    logic deny;
    logic div_busy;
    logic out_free;
  } ptb_sts_t;

endpackage

// File: design/ptb_div.sv
`timescale 1ns / 1ps
// Radix-4 restoring divider for the wait time, with saturation.
module ptb_div import ptb_pkg::*; #(
  parameter int FRAC_BITS = PTB_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CELL_W+FRAC_BITS-1:0]   num,
  input  logic [RATE_W-1:0]             den,
  output logic                          busy,
  output logic [WAIT_W-1:0]             wait_q
);

  localparam int NUM_W = CELL_W + FRAC_BITS;
  localparam int DIV_W = NUM_W + FRAC_BITS;
  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  quo;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] rem_next;
  logic [CNT_W-1:0]  cnt;
  logic [RATE_W:0]   r1;
  logic [RATE_W:0]   r2;
  logic              q1;
  logic              q2;

  // two quotient bits per cycle
  always_comb begin
    r1 = {rem, dvd[DIV_W-1]};
    q1 = (r1 >= {1'b0, den});
    if (q1) begin
      r1 = r1 - {1'b0, den};
    end
    r2 = {r1[RATE_W-1:0], dvd[DIV_W-2]};
    q2 = (r2 >= {1'b0, den});
    if (q2) begin
      r2 = r2 - {1'b0, den};
    end
    rem_next = r2[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num, {FRAC_BITS{1'b0}}};
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-3:0], 2'b00};
      rem <= rem_next;
      quo <= {quo[DIV_W-3:0], q1, q2};
    end
  end

  generate
    if (DIV_W > WAIT_W) begin : g_sat
      assign wait_q = (|quo[DIV_W-1:WAIT_W]) ? {WAIT_W{1'b1}} : quo[WAIT_W-1:0];
    end else begin : g_fit
      assign wait_q = WAIT_W'(quo);
    end
  endgenerate

endmodule

// File: design/ptb_dpath.sv
`timescale 1ns / 1ps
// Datapath: config registers, bucket table, refill arithmetic, output register.
module ptb_dpath import ptb_pkg::*; #(
  parameter int FLOWS     = PTB_FLOWS,
  parameter int FRAC_BITS = PTB_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptb_cmd_t             cmd,
  output ptb_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [FLOW_W-1:0]    flow_index,
  input  logic [CELL_W-1:0]    cell_count,
  input  logic [TICK_W-1:0]    now_tick,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 granted,
  output logic [WAIT_W-1:0]    wait_time
);

  localparam int IDX_W     = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int LVL_W     = CELL_W + FRAC_BITS;
  localparam int ENT_W     = 1 + TICK_W + LVL_W;
  localparam int ACC_W     = TICK_W + RATE_W;
  localparam int RED_SPLIT = FLOW_W / 2;

  // configuration
  logic [RATE_W-1:0] refill_rate;
  logic [CELL_W-1:0] burst_size;

  // per-item registers
  logic [FLOW_W-1:0]  flow_part;
  logic [FLOW_W-1:0]  part_next;
  logic [FLOW_W-1:0]  red_lo;
  logic [IDX_W-1:0]   addr;
  logic [IDX_W-1:0]   addr_next;
  logic [CELL_W-1:0]  cells;
  logic [TICK_W-1:0]  now;
  logic [LVL_W-1:0]   level;
  logic [LVL_W-1:0]   room;
  logic               full;
  logic [TICK_W-1:0]  dt;
  logic [2*MUL_W-1:0] prod;
  logic [ACC_W-1:0]   acc;
  logic               res_grant;

  // table
  logic [ENT_W-1:0]   mem [FLOWS];
  logic [ENT_W-1:0]   rd_data;
  logic [IDX_W-1:0]   clr_addr;

  logic [LVL_W-1:0]   cap;
  logic [LVL_W-1:0]   cells_fx;
  logic               ent_valid;
  logic [TICK_W-1:0]  ent_last;
  logic [LVL_W-1:0]   ent_level;
  logic [TICK_W-1:0]  last_v;
  logic [MUL_W-1:0]   mul_a;
  logic               deny;
  logic               div_start;
  logic               div_busy;
  logic [WAIT_W-1:0]  div_q;

  assign cap       = {burst_size, {FRAC_BITS{1'b0}}};
  assign cells_fx  = {cells, {FRAC_BITS{1'b0}}};
  assign ent_valid = rd_data[ENT_W-1];
  assign ent_last  = rd_data[ENT_W-2 -: TICK_W];
  assign ent_level = rd_data[LVL_W-1:0];
  assign last_v    = ent_valid ? ent_last : now;
  assign deny      = (cells_fx > level);
  assign div_start = cmd.charge && deny;

  // flow index modulo FLOWS: upper half of the reduction at accept,
  // lower half when the table is addressed
  always_comb begin
    part_next = flow_index;
    for (int k = FLOW_W - 1; k >= RED_SPLIT; k--) begin
      if ((FLOWS << k) < (1 << FLOW_W) && 32'(part_next) >= (FLOWS << k)) begin
        part_next = part_next - FLOW_W'(FLOWS << k);
      end
    end
  end

  always_comb begin
    red_lo = flow_part;
    for (int k = RED_SPLIT - 1; k >= 0; k--) begin
      if ((FLOWS << k) < (1 << FLOW_W) && 32'(red_lo) >= (FLOWS << k)) begin
        red_lo = red_lo - FLOW_W'(FLOWS << k);
      end
    end
    addr_next = IDX_W'(red_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refill_rate <= '0;
      burst_size  <= '0;
    end else if (cfg_we) begin
      case (ptb_reg_t'(cfg_index))
        REG_REFILL_RATE: refill_rate <= cfg_data[RATE_W-1:0];
        REG_BURST_SIZE:  burst_size  <= cfg_data[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep over the table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (cmd.charge) begin
      mem[addr] <= {1'b1, now, deny ? level : (level - cells_fx)};
    end
    if (cmd.read) begin
      rd_data <= mem[addr_next];
    end
  end

  assign mul_a = cmd.mul_hi ? MUL_W'(dt[TICK_W-1:MUL_W]) : dt[MUL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      flow_part <= part_next;
      cells     <= cell_count;
      now       <= now_tick;
      res_grant <= 1'b1;
    end
    if (cmd.read) begin
      addr <= addr_next;
    end
    if (cmd.load_entry) begin
      level <= ent_valid ? ent_level : cap;
      dt    <= (now >= last_v) ? (now - last_v) : '0;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod <= mul_a * refill_rate;
    end
    if (cmd.mul_lo) begin
      room <= cap - level;
      full <= (level >= cap);
    end
    if (cmd.mul_hi) begin
      acc <= ACC_W'(prod);
    end
    if (cmd.acc) begin
      acc <= acc + ACC_W'({prod, {MUL_W{1'b0}}});
    end
    if (cmd.refill) begin
      level <= (full || acc > ACC_W'(room)) ? cap : (level + LVL_W'(acc));
    end
    if (cmd.charge) begin
      res_grant <= !deny;
    end
  end

  ptb_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (cells_fx - level),
    .den    (refill_rate),
    .busy   (div_busy),
    .wait_q (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      granted   <= res_grant;
      wait_time <= res_grant ? '0 : div_q;
    end
  end

  assign sts.clr_last  = (clr_addr == IDX_W'(FLOWS - 1));
  assign sts.rate_zero = (refill_rate == '0);
  assign sts.deny      = deny;
  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_valid || out_ready;

  a_level_capped: assert property (@(posedge clk) disable iff (rst)
    cmd.charge |-> level <= cap)
    else $error("level above capacity at charge");

  a_grant_no_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> wait_time == '0)
    else $error("granted word carries a wait");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    cmd.charge |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// File: design/ptb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing one request through the datapath.
module ptb_ctrl import ptb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ptb_sts_t sts,
  output ptb_cmd_t cmd
);

  ptb_state_t state;
  ptb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = sts.rate_zero ? S_RESULT : S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_entry = 1'b1;
        state_next     = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_REFILL;
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_next = S_CHARGE;
      end
      S_CHARGE: begin
        cmd.charge = 1'b1;
        state_next = sts.deny ? S_DIV : S_RESULT;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/per_flow_token_bucket.sv
`timescale 1ns / 1ps
// Top level of the per-flow token bucket rate limiter.
//
// Per-flow token bucket policer. Each request word names a flow, a cell count
// and the current tick; the block refills that flow's bucket (Q32.16 level,
// capped at burst_size) by elapsed ticks times refill_rate, then either
// deducts the cells and grants, or keeps the level and returns the wait in
// Q40.16 ticks, saturating at 2^56-1. A flow seen for the first time starts
// full; time running backwards counts as no elapsed time. With refill_rate
// zero every request is granted at once and no state changes. After reset
// the block sweeps the bucket table to clear the entry valid flags, one
// entry per cycle, over all FLOWS entries (1024 at default), before taking the first
// request; config writes are taken during the sweep. One request is in
// flight at a time, set by the sequencer: a grant steps through read,
// entry load, the low and high multiply passes, accumulate, refill and
// charge before its result word is loaded, and the next request is taken
// once the result is loaded; a denial adds a wait on the radix-4 wait
// divider before the result; with limiting disabled the sequencer goes
// from accept straight to loading the result word. The refill product
// is formed on one 32x32 multiplier in two passes. A finished result word
// sits in an output register, so a stalled output only holds the block
// when the next result is ready to be loaded.
module per_flow_token_bucket import ptb_pkg::*; #(
  parameter int FLOWS     = PTB_FLOWS,
  parameter int FRAC_BITS = PTB_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FLOW_W-1:0]    flow_index,
  input  logic [CELL_W-1:0]    cell_count,
  input  logic [TICK_W-1:0]    now_tick,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 granted,
  output logic [WAIT_W-1:0]    wait_time
);

  ptb_cmd_t cmd;
  ptb_sts_t sts;

  // sequencer: one state per datapath step
  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bucket table, refill math, wait divider and result register
  ptb_dpath #(
    .FLOWS     (FLOWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .flow_index (flow_index),
    .cell_count (cell_count),
    .now_tick   (now_tick),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .granted    (granted),
    .wait_time  (wait_time)
  );

endmodule
